@@ sv/cbar_pkg.sv @@
// ----------------------------------------------------------------------------
// cbar_pkg
// Shared types and constants of the click burst auto repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cbar_pkg;

   // Field widths of the configuration registers and the input item.
   localparam int unsigned MS_W     = 16;
   localparam int unsigned BURST_W  = 4;
   localparam int unsigned JITTER_W = 6;

   // Configuration port shape.
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   // The burst test never looks deeper than the largest burst count.
   localparam int unsigned BURST_MAX = (1 << BURST_W) - 1;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LONG_PRESS   = 3'd0,
      REG_BURST_COUNT  = 3'd1,
      REG_BURST_WINDOW = 3'd2,
      REG_REPEAT_INTVL = 3'd3,
      REG_IDLE_TIMEOUT = 3'd4
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [MS_W-1:0]    LONG_PRESS_RST   = 16'd150;
   localparam logic [BURST_W-1:0] BURST_COUNT_RST  = 4'd5;
   localparam logic [MS_W-1:0]    BURST_WINDOW_RST = 16'd1000;
   localparam logic [MS_W-1:0]    REPEAT_INTVL_RST = 16'd90;
   localparam logic [MS_W-1:0]    IDLE_TIMEOUT_RST = 16'd350;

   // Status from the press history to the tick logic.
   typedef struct packed {
      logic burst_ok;
      logic idle_expired;
   } hist_status_type;

endpackage

`default_nettype wire

@@ sv/cbar_press_hist.sv @@
// ----------------------------------------------------------------------------
// cbar_press_hist
// History of recent press times as a shift line, newest first, with the burst
// and inactivity checks against the current tick time.
// ----------------------------------------------------------------------------
`default_nettype none

module cbar_press_hist
   import cbar_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 8,
   parameter int unsigned TIME_BITS  = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [TIME_BITS-1:0] now_i,
   input  wire logic                 record_i,
   input  wire logic [BURST_W-1:0]   burst_count_i,
   input  wire logic [MS_W-1:0]      burst_window_i,
   input  wire logic [MS_W-1:0]      idle_timeout_i,
   output hist_status_type           status_o
);

   // Only the newest entries can take part in a burst test.
   localparam int unsigned KEEP  = (RING_DEPTH < BURST_MAX) ? RING_DEPTH : BURST_MAX;
   localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > BURST_W) ? CNT_W : BURST_W;

   logic [TIME_BITS-1:0] hist_ff [KEEP];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEEP-1:0]      hit;
   logic                 all_hit;
   logic [TIME_BITS-1:0] newest_age;

   always_ff @(posedge clock) begin
      if (record_i) begin
         hist_ff[0] <= now_i;
         for (int i = 1; i < KEEP; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (record_i && (count_ff != CNT_W'(RING_DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Each entry is checked against the window on its own; entries older than
   // the burst count are don't-cares.
   always_comb begin
      all_hit = 1'b1;
      for (int i = 0; i < KEEP; i++) begin
         hit[i] = ((now_i - hist_ff[i]) <= TIME_BITS'(burst_window_i));
         if ((i < int'(burst_count_i)) && !hit[i]) begin
            all_hit = 1'b0;
         end
      end
   end

   assign newest_age = now_i - hist_ff[0];

   always_comb begin
      status_o.burst_ok = (burst_count_i == '0) ||
                          ((CMP_W'(burst_count_i) <= CMP_W'(count_ff)) && all_hit);
      status_o.idle_expired = (count_ff == '0) ||
                              (newest_age > TIME_BITS'(idle_timeout_i));
   end

endmodule

`default_nettype wire

@@ sv/click_burst_auto_repeat_unit.sv @@
// ----------------------------------------------------------------------------
// click_burst_auto_repeat_unit
// Millisecond-tick button processor: long press detection, burst detection
// into auto repeat mode, and jittered generated clicks while in that mode.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                    Direction
//   -------   --------------------------------------   ---------
//   req       req_valid, req_stall, req_button_level,   in
//             req_jitter_offset
//   rsp       rsp_valid, rsp_stall, rsp_click_pulse,    out
//             rsp_auto_mode, rsp_long_hold
//   csr       csr_write_enable, csr_index,              in
//             csr_write_data
//
// One tick word is accepted per cycle unless req is stalled. A word waits in the
// input register, where the tick logic checks it against the block state, and
// its result goes to the output register once that register is free. A stalled
// output register holds the input register, which then stalls req. Reset is
// synchronous and returns valid flags, configuration and state to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module click_burst_auto_repeat_unit
   import cbar_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 8,
   parameter int unsigned TIME_BITS  = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_button_level,
   input  wire logic signed [JITTER_W-1:0] req_jitter_offset,

   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic                       rsp_click_pulse,
   output      logic                       rsp_auto_mode,
   output      logic                       rsp_long_hold,

   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_write_data
);

   // The repeat delay is an 18 bit signed sum; compares against elapsed time
   // are done at a width that holds both.
   localparam int unsigned DELAY_W = MS_W + 2;
   localparam int unsigned CMP_W   = (TIME_BITS > DELAY_W - 1) ? TIME_BITS : DELAY_W - 1;

   // Configuration registers.
   logic [MS_W-1:0]    long_press_ff;
   logic [BURST_W-1:0] burst_count_ff;
   logic [MS_W-1:0]    burst_window_ff;
   logic [MS_W-1:0]    repeat_intvl_ff;
   logic [MS_W-1:0]    idle_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RST;
         burst_count_ff  <= BURST_COUNT_RST;
         burst_window_ff <= BURST_WINDOW_RST;
         repeat_intvl_ff <= REPEAT_INTVL_RST;
         idle_timeout_ff <= IDLE_TIMEOUT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LONG_PRESS:   long_press_ff   <= csr_write_data;
            REG_BURST_COUNT:  burst_count_ff  <= csr_write_data[BURST_W-1:0];
            REG_BURST_WINDOW: burst_window_ff <= csr_write_data;
            REG_REPEAT_INTVL: repeat_intvl_ff <= csr_write_data;
            REG_IDLE_TIMEOUT: idle_timeout_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Input register and handshake. The word in the input register is handled
   // in the cycle the output register can take its result.
   logic                       in_valid_ff, in_valid_in;
   logic                       in_level_ff;
   logic signed [JITTER_W-1:0] in_jitter_ff;
   logic                       out_free;
   logic                       fire;
   logic                       req_take;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff  <= req_button_level;
         in_jitter_ff <= req_jitter_offset;
      end
   end

   // Block state.
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic [TIME_BITS-1:0] last_gen_ff, last_gen_in;
   logic                 prev_level_ff, prev_level_in;
   logic                 long_ff, long_in;
   logic                 auto_ff, auto_in;
   logic                 click;
   logic                 record;
   hist_status_type      hist_status;

   cbar_press_hist #(
      .RING_DEPTH (RING_DEPTH),
      .TIME_BITS  (TIME_BITS)
   ) u_press_hist (
      .clock          (clock),
      .reset          (reset),
      .now_i          (tick_ff),
      .record_i       (record),
      .burst_count_i  (burst_count_ff),
      .burst_window_i (burst_window_ff),
      .idle_timeout_i (idle_timeout_ff),
      .status_o       (hist_status)
   );

   // Tick logic. A level change only handles the edge: a press restarts the
   // hold timer and is recorded, a release of a short press decides auto mode
   // from the burst test. A steady level checks for a long hold, which leaves auto
   // mode, generates a click when due while released in auto mode, and ends auto
   // mode after the inactivity timeout.
   logic signed [DELAY_W-1:0] delay;
   logic                      delay_pos;
   logic [TIME_BITS-1:0]      hold_time;
   logic [TIME_BITS-1:0]      since_click;
   logic                      auto_mid;

   assign delay       = $signed({2'b00, repeat_intvl_ff}) + DELAY_W'(in_jitter_ff);
   assign delay_pos   = !delay[DELAY_W-1] && (delay != '0);
   assign hold_time   = tick_ff - press_start_ff;
   assign since_click = tick_ff - last_gen_ff;

   always_comb begin
      tick_in        = tick_ff;
      press_start_in = press_start_ff;
      last_gen_in    = last_gen_ff;
      prev_level_in  = prev_level_ff;
      long_in        = long_ff;
      auto_in        = auto_ff;
      auto_mid       = auto_ff;
      click          = 1'b0;
      record         = 1'b0;
      if (fire) begin
         tick_in = tick_ff + TIME_BITS'(1);
         if (in_level_ff == prev_level_ff) begin
            if (in_level_ff && !long_ff && (hold_time >= TIME_BITS'(long_press_ff))) begin
               long_in  = 1'b1;
               auto_mid = 1'b0;
            end
            auto_in = auto_mid;
            if (auto_mid && !in_level_ff) begin
               if (!delay_pos ||
                   (CMP_W'(since_click) >= CMP_W'(delay[DELAY_W-2:0]))) begin
                  click       = 1'b1;
                  last_gen_in = tick_ff;
               end
            end
            if (auto_mid && hist_status.idle_expired) begin
               auto_in = 1'b0;
            end
         end else begin
            if (in_level_ff) begin
               press_start_in = tick_ff;
               long_in        = 1'b0;
               record         = 1'b1;
            end else if (!long_ff) begin
               auto_in = hist_status.burst_ok;
            end
            prev_level_in = in_level_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         press_start_ff <= '0;
         last_gen_ff    <= '0;
         prev_level_ff  <= 1'b0;
         long_ff        <= 1'b0;
         auto_ff        <= 1'b0;
      end else begin
         tick_ff        <= tick_in;
         press_start_ff <= press_start_in;
         last_gen_ff    <= last_gen_in;
         prev_level_ff  <= prev_level_in;
         long_ff        <= long_in;
         auto_ff        <= auto_in;
      end
   end

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_click_ff;
   logic rsp_auto_ff;
   logic rsp_long_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_click_ff <= click;
         rsp_auto_ff  <= auto_in;
         rsp_long_ff  <= long_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_click_pulse = rsp_click_ff;
   assign rsp_auto_mode   = rsp_auto_ff;
   assign rsp_long_hold   = rsp_long_ff;

endmodule

`default_nettype wire
